[src/assert_macros.svh]
// Assertion helpers used by the rre_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, including while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// Check a property at every clock edge outside reset.
`define ASSERT_ACTIVE(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

[src/rre_pkg.sv]
package rre_pkg;

  localparam int TIME_W    = 48;
  localparam int VAL_W     = 32;
  localparam int GAIN_W    = 9;
  localparam int FACT_W    = 8;
  localparam int ACC_W     = VAL_W + FACT_W;   // widest sum of two weighted products
  localparam int KV_W      = ACC_W - 4;        // Q4.4 product with fraction dropped
  localparam int SUM_W     = KV_W + 1;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(256);
  localparam logic [ACC_W-1:0]  RND_Q08    = ACC_W'(128);
  localparam logic [ACC_W-1:0]  RND_Q44    = ACC_W'(8);
  localparam logic [CNT_W-1:0]  GAIN_STEPS = CNT_W'(GAIN_W);
  localparam logic [CNT_W-1:0]  FACT_STEPS = CNT_W'(FACT_W);

  localparam logic [GAIN_W-1:0] ALPHA_RST   = GAIN_W'(32);
  localparam logic [GAIN_W-1:0] BETA_RST    = GAIN_W'(64);
  localparam logic [FACT_W-1:0] VGAIN_RST   = FACT_W'(64);
  localparam logic [VAL_W-1:0]  CEILING_RST = VAL_W'(960000);
  localparam logic [FACT_W-1:0] BACKOFF_RST = FACT_W'(32);
  localparam logic [VAL_W-1:0]  START_RST   = VAL_W'(16000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_VGAIN   = 3'd2,
    REG_CEILING = 3'd3,
    REG_BACKOFF = 3'd4,
    REG_START   = 3'd5
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RTT  = 10'b0000000010,
    ST_CHK  = 10'b0000000100,
    ST_VARA = 10'b0000001000,
    ST_VARB = 10'b0000010000,
    ST_SRTA = 10'b0000100000,
    ST_SRTB = 10'b0001000000,
    ST_KVAR = 10'b0010000000,
    ST_BOFF = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

endpackage

[src/rtt_rto_estimator.sv]
// Retransmission-timeout estimator with Jacobson/Karels style smoothing.
// Input channel (in_valid/in_ready): func = 0 carries an rtt sample
// (now_time, sent_time); func = 1 asks for a timeout backoff of rto.
// Output channel (out_valid/out_ready): one transfer per input transfer with
// rto_value, smoothed_rtt, rtt_variation and sample_used after that item.
// Configuration: cfg_wen/cfg_index/cfg_data write one register per cycle;
// the user must write them only while the block is idle, which the block
// does not enforce; writing start_rto before the first sample also loads rto.
// All products run through one shift-add multiplier that retires one bit
// of the 8/9-bit gain per cycle; a sample update takes four 9-bit passes
// plus one 8-bit pass, a first sample or a backoff one 8-bit pass, and a
// skipped sample none.
// One item is in flight at a time; the next transfer can be taken in the
// cycle after the result is loaded.
// The output register holds a finished result while the receiver stalls;
// the block accepts and works on the next item meanwhile and waits to load
// its result until the register is free.
// Reset (synchronous, rst high) loads the default register values, clears
// srtt, rttvar and the sample history, sets rto to start_rto and empties
// the output register.
module rtt_rto_estimator import rre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [TIME_W-1:0]    now_time,
  input  logic [TIME_W-1:0]    sent_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VAL_W-1:0]     rto_value,
  output logic [VAL_W-1:0]     smoothed_rtt,
  output logic [VAL_W-1:0]     rtt_variation,
  output logic                 sample_used
);

  // configuration registers; start_rto only matters at the moment it is
  // written, so before the first sample it goes straight into rto
  logic [GAIN_W-1:0] alpha_weight;
  logic [GAIN_W-1:0] beta_weight;
  logic [FACT_W-1:0] variance_gain;
  logic [VAL_W-1:0]  rto_ceiling;
  logic [FACT_W-1:0] backoff_factor;

  // estimator state
  logic [VAL_W-1:0]  srtt_reg;
  logic [VAL_W-1:0]  rttvar_reg;
  logic [VAL_W-1:0]  rto_reg;
  logic [TIME_W-1:0] last_update_time;
  logic              have_sample;

  state_t state;

  // captured item and working values
  logic              cap_func;
  logic [TIME_W-1:0] cap_now;
  logic [TIME_W-1:0] cap_sent;
  logic [VAL_W-1:0]  rtt;
  logic [VAL_W-1:0]  diff;
  logic [VAL_W-1:0]  new_var;
  logic [VAL_W-1:0]  new_srtt;
  logic              first_smp;
  logic              used;

  // shift-add multiplier: multiplicand shifts left, multiplier shifts right
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mcand;
  logic [GAIN_W-1:0] mplr;
  logic [CNT_W-1:0]  cnt;

  logic [GAIN_W-1:0] alpha_eff, beta_eff, alpha_inv, beta_inv;
  logic [ACC_W-1:0]  acc_step;
  logic              mac_last;
  logic [TIME_W:0]   rtt_wide, pass_wide;
  logic [VAL_W-1:0]  rtt_calc, diff_calc;
  logic              passed_ok;
  logic [KV_W-1:0]   prod_hi;
  logic [SUM_W-1:0]  rto_sum;
  logic [VAL_W-1:0]  rto_sat, rto_clamp, boff_sat, boff_clamp;

  assign in_ready = (state == ST_IDLE);

  // weights above one act as one
  assign alpha_eff = (alpha_weight > GAIN_ONE) ? GAIN_ONE : alpha_weight;
  assign beta_eff  = (beta_weight > GAIN_ONE) ? GAIN_ONE : beta_weight;
  assign alpha_inv = GAIN_ONE - alpha_eff;
  assign beta_inv  = GAIN_ONE - beta_eff;

  assign acc_step = acc + (mplr[0] ? mcand : '0);
  assign mac_last = (cnt == CNT_W'(1));

  // rtt: zero when the send time is later, saturate above 32 bits
  assign rtt_wide = {1'b0, cap_now} - {1'b0, cap_sent};
  assign rtt_calc = rtt_wide[TIME_W] ? '0 :
                    (|rtt_wide[TIME_W-1:VAL_W]) ? '1 : rtt_wide[VAL_W-1:0];

  // time since the last update; a clock that went back counts as zero
  assign pass_wide = {1'b0, cap_now} - {1'b0, last_update_time};
  assign passed_ok = !pass_wide[TIME_W] &&
                     (pass_wide[TIME_W-1:0] > {{(TIME_W-VAL_W){1'b0}}, srtt_reg});

  assign diff_calc = (srtt_reg >= rtt) ? (srtt_reg - rtt) : (rtt - srtt_reg);

  // final product of a Q4.4 pass with the fraction dropped
  assign prod_hi = acc_step[ACC_W-1:4];

  assign rto_sum   = {{(SUM_W-VAL_W){1'b0}}, new_srtt} + {1'b0, prod_hi};
  assign rto_sat   = (|rto_sum[SUM_W-1:VAL_W]) ? '1 : rto_sum[VAL_W-1:0];
  assign rto_clamp = (rto_sat > rto_ceiling) ? rto_ceiling : rto_sat;

  assign boff_sat   = (|prod_hi[KV_W-1:VAL_W]) ? '1 : prod_hi[VAL_W-1:0];
  assign boff_clamp = (boff_sat > rto_ceiling) ? rto_ceiling : boff_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_weight     <= ALPHA_RST;
      beta_weight      <= BETA_RST;
      variance_gain    <= VGAIN_RST;
      rto_ceiling      <= CEILING_RST;
      backoff_factor   <= BACKOFF_RST;
      srtt_reg         <= '0;
      rttvar_reg       <= '0;
      rto_reg          <= START_RST;
      last_update_time <= '0;
      have_sample      <= 1'b0;
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
    end else begin
      // configuration writes must arrive only while idle; the user is bound to this, the block does not enforce it
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_ALPHA:   alpha_weight   <= cfg_data[GAIN_W-1:0];
          REG_BETA:    beta_weight    <= cfg_data[GAIN_W-1:0];
          REG_VGAIN:   variance_gain  <= cfg_data[FACT_W-1:0];
          REG_CEILING: rto_ceiling    <= cfg_data;
          REG_BACKOFF: backoff_factor <= cfg_data[FACT_W-1:0];
          REG_START: begin
            if (!have_sample) rto_reg <= cfg_data;
          end
          default: ;
        endcase
      end

      // drop the result once the receiver takes it, unless a new one loads now
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;

      // advance the multiplier by one bit in every multiply state; the last
      // step of a pass is handled by the state itself
      if ((state == ST_VARA || state == ST_VARB || state == ST_SRTA ||
           state == ST_SRTB || state == ST_KVAR || state == ST_BOFF) && !mac_last) begin
        acc   <= acc_step;
        mcand <= mcand << 1;
        mplr  <= mplr >> 1;
        cnt   <= cnt - CNT_W'(1);
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cap_func <= func;
            cap_now  <= now_time;
            cap_sent <= sent_time;
            state    <= ST_RTT;
          end
        end
        ST_RTT: begin
          used      <= 1'b0;
          first_smp <= 1'b0;
          if (cap_func) begin
            acc   <= RND_Q44;
            mcand <= ACC_W'(rto_reg);
            mplr  <= {1'b0, backoff_factor};
            cnt   <= FACT_STEPS;
            state <= ST_BOFF;
          end else begin
            rtt   <= rtt_calc;
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (!have_sample) begin
            first_smp <= 1'b1;
            new_srtt  <= rtt;
            new_var   <= rtt >> 1;
            acc       <= RND_Q44;
            mcand     <= ACC_W'(rtt >> 1);
            mplr      <= {1'b0, variance_gain};
            cnt       <= FACT_STEPS;
            state     <= ST_KVAR;
          end else if (passed_ok) begin
            diff  <= diff_calc;
            acc   <= RND_Q08;
            mcand <= ACC_W'(rttvar_reg);
            mplr  <= beta_inv;
            cnt   <= GAIN_STEPS;
            state <= ST_VARA;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_VARA: begin
          if (mac_last) begin
            acc   <= acc_step;
            mcand <= ACC_W'(diff);
            mplr  <= beta_eff;
            cnt   <= GAIN_STEPS;
            state <= ST_VARB;
          end
        end
        ST_VARB: begin
          if (mac_last) begin
            new_var <= acc_step[ACC_W-1:8];
            acc     <= RND_Q08;
            mcand   <= ACC_W'(srtt_reg);
            mplr    <= alpha_inv;
            cnt     <= GAIN_STEPS;
            state   <= ST_SRTA;
          end
        end
        ST_SRTA: begin
          if (mac_last) begin
            acc   <= acc_step;
            mcand <= ACC_W'(rtt);
            mplr  <= alpha_eff;
            cnt   <= GAIN_STEPS;
            state <= ST_SRTB;
          end
        end
        ST_SRTB: begin
          if (mac_last) begin
            new_srtt <= acc_step[ACC_W-1:8];
            acc      <= RND_Q44;
            mcand    <= ACC_W'(new_var);
            mplr     <= {1'b0, variance_gain};
            cnt      <= FACT_STEPS;
            state    <= ST_KVAR;
          end
        end
        ST_KVAR: begin
          if (mac_last) begin
            // the first sample sets rto without the ceiling and keeps the update time
            srtt_reg    <= new_srtt;
            rttvar_reg  <= new_var;
            rto_reg     <= first_smp ? rto_sat : rto_clamp;
            have_sample <= 1'b1;
            if (!first_smp) last_update_time <= cap_now;
            used        <= 1'b1;
            state       <= ST_DONE;
          end
        end
        ST_BOFF: begin
          if (mac_last) begin
            rto_reg <= boff_clamp;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            rto_value     <= rto_reg;
            smoothed_rtt  <= srtt_reg;
            rtt_variation <= rttvar_reg;
            sample_used   <= used;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/rre_checker.sv]
`include "assert_macros.svh"

module rre_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rto_value,
  input logic        sample_used
);

  // a stalled result keeps its value
  `ASSERT_ACTIVE(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(rto_value) && $stable(sample_used))

  // reset empties the output register and opens the input
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid && in_ready)

  // one item at a time: the input closes right after a transfer
  `ASSERT_ACTIVE(a_busy_after_take, clk, rst, in_valid && in_ready |=> !in_ready)

endmodule

bind rtt_rto_estimator rre_checker u_rre_checker (.*);

[tb/rre_tb_pkg.sv]
package rre_tb_pkg;

  // Item kinds on the func field of the input channel
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_BACKOFF = 1'b1
  } op_t;

endpackage

[tb/rto_checker.sv]
module rto_checker
  import rre_pkg::*;
  import rre_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 func,
  input  logic [TIME_W-1:0]    now_time,
  input  logic [TIME_W-1:0]    sent_time,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VAL_W-1:0]     rto_value,
  input  logic [VAL_W-1:0]     smoothed_rtt,
  input  logic [VAL_W-1:0]     rtt_variation,
  input  logic                 sample_used,
  output int                   outstanding,
  output int                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] rto;
    logic [VAL_W-1:0] srtt;
    logic [VAL_W-1:0] rttvar;
    logic             used;
  } estimate_t;

  estimate_t estimate_q[$];

  // Register copies
  logic [GAIN_W-1:0] alpha_w;
  logic [GAIN_W-1:0] beta_w;
  logic [FACT_W-1:0] k_gain;
  logic [VAL_W-1:0]  rto_max;
  logic [FACT_W-1:0] backoff_mul;

  // Estimator state
  logic [VAL_W-1:0]  srtt;
  logic [VAL_W-1:0]  rttvar;
  logic [VAL_W-1:0]  rto;
  logic [TIME_W-1:0] last_update;
  logic              seeded;

  function automatic logic [VAL_W-1:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[VAL_W-1:0];
  endfunction

  function automatic logic [63:0] gain_cap(input logic [GAIN_W-1:0] w);
    return (w > 9'd256) ? 64'd256 : 64'(w);
  endfunction

  function automatic logic [VAL_W-1:0] ceiling_cap(input logic [VAL_W-1:0] v);
    return (v > rto_max) ? rto_max : v;
  endfunction

  function automatic logic [VAL_W-1:0] rto_from(input logic [VAL_W-1:0] s,
                                                input logic [VAL_W-1:0] v);
    logic [63:0] kv;
    kv = (64'(k_gain) * 64'(v) + 64'd8) >> 4;
    return sat32(64'(s) + kv);
  endfunction

  // Advance the estimator by one item and return what the block reports
  task automatic update_estimate(input op_t op, input logic [TIME_W-1:0] now,
                                 input logic [TIME_W-1:0] sent, output estimate_t res);
    logic [63:0] rtt;
    logic [63:0] passed;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] dev;
    res.used = 1'b0;
    if (op == OP_BACKOFF) begin
      rto = ceiling_cap(sat32((64'(rto) * 64'(backoff_mul) + 64'd8) >> 4));
    end else begin
      rtt = (now >= sent) ? 64'(now - sent) : 64'd0;
      rtt = 64'(sat32(rtt));
      if (!seeded) begin
        // first sample is not clamped and leaves last_update alone
        srtt     = rtt[VAL_W-1:0];
        rttvar   = srtt >> 1;
        rto      = rto_from(srtt, rttvar);
        seeded   = 1'b1;
        res.used = 1'b1;
      end else begin
        passed = (now >= last_update) ? 64'(now - last_update) : 64'd0;
        if (passed > 64'(srtt)) begin
          a   = gain_cap(alpha_w);
          b   = gain_cap(beta_w);
          dev = (64'(srtt) >= rtt) ? 64'(srtt) - rtt : rtt - 64'(srtt);
          rttvar = VAL_W'(((64'd256 - b) * 64'(rttvar) + b * dev + 64'd128) >> 8);
          srtt   = VAL_W'(((64'd256 - a) * 64'(srtt) + a * rtt + 64'd128) >> 8);
          rto         = ceiling_cap(rto_from(srtt, rttvar));
          last_update = now;
          res.used    = 1'b1;
        end
      end
    end
    res.rto    = rto;
    res.srtt   = srtt;
    res.rttvar = rttvar;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    estimate_t want;
    estimate_t next;
    if (rst) begin
      alpha_w     = ALPHA_RST;
      beta_w      = BETA_RST;
      k_gain      = VGAIN_RST;
      rto_max     = CEILING_RST;
      backoff_mul = BACKOFF_RST;
      srtt        = '0;
      rttvar      = '0;
      rto         = START_RST;
      last_update = '0;
      seeded      = 1'b0;
      estimate_q.delete();
    end else begin
      // retire the oldest expectation before taking a new one in the same cycle
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing outstanding, rto %0d",
                                    rto_value));
        end else begin
          want = estimate_q.pop_front();
          check_field("rto_value", rto_value, want.rto);
          check_field("smoothed_rtt", smoothed_rtt, want.srtt);
          check_field("rtt_variation", rtt_variation, want.rttvar);
          check_field("sample_used", VAL_W'(sample_used), VAL_W'(want.used));
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_ALPHA:   alpha_w     = cfg_data[GAIN_W-1:0];
          REG_BETA:    beta_w      = cfg_data[GAIN_W-1:0];
          REG_VGAIN:   k_gain      = cfg_data[FACT_W-1:0];
          REG_CEILING: rto_max     = cfg_data;
          REG_BACKOFF: backoff_mul = cfg_data[FACT_W-1:0];
          REG_START: begin
            if (!seeded) rto = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        update_estimate(op_t'(func), now_time, sent_time, next);
        estimate_q = {estimate_q, next};
      end
    end
    outstanding = estimate_q.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rre_pkg::*;
  import rre_tb_pkg::*;

  // Register indexes the block does not decode; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 400;   // long enough to fill the block many times over
  localparam int DRAIN_CYCLES    = 60;    // slowest item is a full sample update
  localparam int CYCLE_LIMIT     = 600000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 func;
  logic [TIME_W-1:0]    now_time;
  logic [TIME_W-1:0]    sent_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [VAL_W-1:0]     rto_value;
  logic [VAL_W-1:0]     smoothed_rtt;
  logic [VAL_W-1:0]     rtt_variation;
  logic                 sample_used;

  int outstanding;
  int mismatches;
  int cycle_count = 0;

  // Pacing controls for the sender and the receiver
  bit tx_steady;
  bit rx_steady;
  bit rx_hold;

  // Wall clock of the traffic model and an upper bound on any rtt sent so far;
  // srtt never exceeds this bound, so stepping past it forces an update.
  logic [TIME_W-1:0] clock_now;
  logic [VAL_W-1:0]  rtt_bound;

  always #1 clk = ~clk;

  rtt_rto_estimator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .now_time     (now_time),
    .sent_time    (sent_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rto_value    (rto_value),
    .smoothed_rtt (smoothed_rtt),
    .rtt_variation(rtt_variation),
    .sample_used  (sample_used)
  );

  rto_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .now_time     (now_time),
    .sent_time    (sent_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rto_value    (rto_value),
    .smoothed_rtt (smoothed_rtt),
    .rtt_variation(rtt_variation),
    .sample_used  (sample_used),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Send time for a packet acknowledged at 'now', with an rtt drawn from the
  // magnitude class of the current phase
  function automatic logic [TIME_W-1:0] sent_before(input logic [TIME_W-1:0] now,
                                                    input int rtt_class);
    logic [TIME_W-1:0] rtt;
    case (rtt_class)
      0:       rtt = TIME_W'($urandom_range(0, 2000));
      1:       rtt = TIME_W'($urandom_range(0, 1 << 20));
      2:       rtt = TIME_W'($urandom);
      default: rtt = rand48() >> 8;
    endcase
    return (rtt <= now) ? now - rtt : '0;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      2:       return VAL_W'($urandom_range(0, 4096)) & top;
      default: return VAL_W'($urandom) & top;
    endcase
  endfunction

  // One register write; call at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  // Offer one item and hold it until the transfer; returns at a falling edge.
  // Valid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input op_t op, input logic [TIME_W-1:0] now,
                           input logic [TIME_W-1:0] sent);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    func      = op;
    now_time  = now;
    sent_time = sent;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send an rtt sample and widen the rtt bound to cover it
  task automatic send_sample(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] sent);
    logic [TIME_W-1:0] span;
    span = (now >= sent) ? now - sent : '0;
    if (span > TIME_W'(rtt_bound))
      rtt_bound = (span > 48'hFFFF_FFFF) ? '1 : span[VAL_W-1:0];
    send_item(OP_SAMPLE, now, sent);
  endtask

  // Drop valid and wait until every result has come back; the block then sits idle
  task automatic quiesce();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold && !hold_taken) begin
        stall_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    int phase;
    int i;
    int pick;
    int rtt_class;
    logic [TIME_W-1:0] now;

    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data  = '0;
    in_valid  = 1'b0;
    func      = OP_SAMPLE;
    now_time  = '0;
    sent_time = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold   = 1'b0;
    rtt_bound = '0;
    // start late enough that a send time of zero gives an rtt past 32 bits
    clock_now = 48'h10_0000_0000 + TIME_W'($urandom);

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // ---------------- directed part ----------------

    // Backoff before any sample works on the start value (16000 after reset)
    send_item(OP_BACKOFF, '1, '1);
    quiesce();
    // Loading start_rto before the first sample replaces rto; a full backoff saturates
    write_reg(REG_START, '1);
    write_reg(REG_BACKOFF, 8'd255);
    write_reg(REG_CEILING, '1);
    send_item(OP_BACKOFF, '0, '1);
    quiesce();
    // Backoff factor below one shrinks rto; then the first sample sets rto
    // well above the small ceiling, since the first load is not clamped
    write_reg(REG_START, 32'd7);
    write_reg(REG_CEILING, 32'd100);
    write_reg(REG_BACKOFF, 8'd3);
    send_item(OP_BACKOFF, rand48(), rand48());
    send_sample(clock_now, clock_now - 48'd5000);
    quiesce();

    // After the first sample a start_rto write leaves rto alone
    write_reg(REG_START, 32'd12345);
    write_reg(REG_CEILING, '1);
    write_reg(REG_BACKOFF, 8'd16);
    write_reg(REG_ALPHA, 32'd256);
    write_reg(REG_BETA, 32'd256);
    write_reg(REG_VGAIN, 32'd255);
    // last update time is still zero, so this one always passes
    clock_now += 48'd10000;
    send_sample(clock_now, clock_now - 48'd800);
    // time going backwards past the last update: skipped
    send_sample(clock_now - 48'd1, clock_now - 48'd900);
    // less than one srtt since the last update: skipped
    send_sample(clock_now + 48'd10, clock_now);
    // send time after current time gives a zero rtt
    clock_now += TIME_W'(rtt_bound) + 48'd1;
    send_sample(clock_now, '1);
    // rtt past 32 bits saturates
    clock_now += TIME_W'(rtt_bound) + 48'd1;
    send_sample(clock_now, '0);
    send_item(OP_BACKOFF, '0, '0);
    quiesce();

    // Zero gains freeze the estimate; a zero ceiling pins rto at zero
    write_reg(REG_ALPHA, '0);
    write_reg(REG_BETA, '0);
    write_reg(REG_VGAIN, '0);
    write_reg(REG_CEILING, '0);
    clock_now += TIME_W'(rtt_bound) + 48'd1;
    send_sample(clock_now, clock_now - 48'd300);
    send_item(OP_BACKOFF, rand48(), rand48());
    quiesce();

    // Gains above one act as one; zero backoff factor
    write_reg(REG_ALPHA, 32'h1FF);
    write_reg(REG_BETA, 32'h1FF);
    write_reg(REG_VGAIN, 32'd1);
    write_reg(REG_CEILING, '1);
    write_reg(REG_BACKOFF, '0);
    write_reg(IDX_SPARE_LO, '1);
    write_reg(IDX_SPARE_HI, '1);
    clock_now += TIME_W'(rtt_bound) + 48'd1;
    send_sample(clock_now, clock_now);
    send_sample('0, '0);
    send_item(OP_BACKOFF, '1, '0);

    // ---------------- random part ----------------

    for (phase = 0; phase < PHASES; phase++) begin
      quiesce();
      if (phase == 1) begin
        write_reg(REG_ALPHA, 32'd256);
        write_reg(REG_BETA, 32'd256);
        write_reg(REG_VGAIN, 32'd255);
        write_reg(REG_CEILING, '1);
        write_reg(REG_BACKOFF, 32'd255);
        write_reg(REG_START, '1);
      end else if (phase == 2) begin
        write_reg(REG_ALPHA, '0);
        write_reg(REG_BETA, '0);
        write_reg(REG_VGAIN, '0);
        write_reg(REG_CEILING, '0);
        write_reg(REG_BACKOFF, 32'd16);
        write_reg(REG_START, '0);
      end else begin
        write_reg(REG_ALPHA, pick_value(32'h1FF));
        write_reg(REG_BETA, pick_value(32'h1FF));
        write_reg(REG_VGAIN, pick_value(32'hFF));
        write_reg(REG_CEILING, pick_value('1));
        write_reg(REG_BACKOFF, pick_value(32'hFF));
        write_reg(REG_START, pick_value('1));
      end
      write_reg(phase[0] ? IDX_SPARE_HI : IDX_SPARE_LO, VAL_W'($urandom));

      rtt_class = phase % 4;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) begin
        // keep offering while the receiver is held off, so the input backs up
        tx_steady = 1'b1;
        rx_hold   = 1'b1;
      end

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // backoff; the time fields carry noise
          send_item(OP_BACKOFF, rand48(), rand48());
        end else if (pick < 15) begin
          // arbitrary send time, often after the current time
          send_sample(clock_now, rand48());
        end else if (pick < 20) begin
          // stamp just behind the current time, often older than the last update
          now = clock_now - TIME_W'($urandom_range(1, 1000));
          send_sample(now, sent_before(now, rtt_class));
        end else if (pick < 40) begin
          // short step, usually within one srtt
          clock_now += TIME_W'($urandom_range(0, rtt_bound >> 2));
          send_sample(clock_now, sent_before(clock_now, rtt_class));
        end else begin
          // step past the rtt bound, so the estimate moves
          clock_now += TIME_W'(rtt_bound) + 48'd1 + TIME_W'($urandom_range(0, rtt_bound));
          send_sample(clock_now, sent_before(clock_now, rtt_class));
        end
      end
    end

    // Time stamp at its top value, then one more backoff
    send_sample('1, '0);
    send_item(OP_BACKOFF, rand48(), rand48());

    // ---------------- wind down ----------------
    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
